FILE: design/hysl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_pkg
// Shared types, constants and the arctangent table of the heading yaw slew
// limiter.
// ----------------------------------------------------------------------------
package hysl_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_WIDTH  = 16;

    localparam int ANG_FRAC  = ANGLE_WIDTH - 3;
    localparam int TAB_SHIFT = 30 - ANG_FRAC;
    localparam int XW        = 27;
    localparam int ZW        = ANGLE_WIDTH + 1;
    localparam int RW        = ANGLE_WIDTH + 4;
    localparam int RND_SHIFT = (ANG_FRAC >= 13) ? (ANG_FRAC - 13) : 0;
    localparam int UP_SHIFT  = (ANG_FRAC < 13) ? (13 - ANG_FRAC) : 0;
    localparam longint RND_HALF = (RND_SHIFT > 0) ? (64'sd1 <<< (RND_SHIFT - 1)) : 0;

    localparam int YAW_PI     = 25736;
    localparam int YAW_TWO_PI = 51472;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOVER_HEIGHT = 3'd0,
        CFG_YAW_STEP_MAX = 3'd1,
        CFG_YAW_RATE_MAX = 3'd2,
        CFG_INV_TICK     = 3'd3,
        CFG_SPEED_SQ_MIN = 3'd4
    } cfg_idx_t;

    localparam longint ATAN_TAB [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef struct packed {
        logic [30:0] hover_height;
        logic [14:0] yaw_step_max;
        logic [14:0] yaw_rate_max;
        logic [15:0] inv_tick;
        logic [31:0] speed_sq_min;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic signed [ZW-1:0] cz;
        logic                 slow;
    } stage_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] aim;
        logic               slow;
    } item_t;

    function automatic logic signed [ZW-1:0] tab_angle(input longint t);
        longint r;
        r = (t + (64'sd1 <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
        return r[ZW-1:0];
    endfunction

endpackage

FILE: design/hysl_point_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_point_if
// Trajectory point channel: position and planar velocity.
// ----------------------------------------------------------------------------
interface hysl_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

FILE: design/hysl_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_cmd_if
// Command channel: position, height, yaw and yaw rate.
// ----------------------------------------------------------------------------
interface hysl_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
    logic        [30:0] cmd_z;
    logic signed [15:0] cmd_yaw;
    logic signed [15:0] cmd_yaw_rate;

    modport source (output valid, cmd_x, cmd_y, cmd_z, cmd_yaw, cmd_yaw_rate, input ready);
    modport sink   (input valid, cmd_x, cmd_y, cmd_z, cmd_yaw, cmd_yaw_rate, output ready);
endinterface

FILE: design/hysl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_front
// Accepts points, squares the speed and runs the pipelined CORDIC that
// yields the aim heading and the slow flag.
// ----------------------------------------------------------------------------
module hysl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hysl_pkg::cfg_t       cfg,
    hysl_point_if.sink           point,
    output logic                 fr_valid,
    input  logic                 fr_ready,
    output hysl_pkg::item_t      fr_data
);
    import hysl_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic               en;
    logic [N+1:0]       v_reg;
    stage_t             st_reg  [0:N];
    stage_t             st_next [0:N];
    logic [30:0]        sqx_reg;
    logic [30:0]        sqy_reg;
    logic signed [31:0] sqx_next;
    logic signed [31:0] sqy_next;
    item_t              item_reg;
    item_t              item_next;
    logic signed [RW-1:0] zx;
    logic signed [RW-1:0] zr;

    assign en          = !v_reg[N+1] || fr_ready;
    assign point.ready = en;
    assign fr_valid    = v_reg[N+1];
    assign fr_data     = item_reg;

    // quadrant pre-rotation and squares
    always_comb
    begin
        logic signed [XW-1:0] x0;
        logic signed [XW-1:0] y0;
        x0 = XW'(point.vel_x) <<< 8;
        y0 = XW'(point.vel_y) <<< 8;
        st_next[0].pos_x = point.pos_x;
        st_next[0].pos_y = point.pos_y;
        st_next[0].slow  = 1'b0;
        st_next[0].cx    = x0;
        st_next[0].cy    = y0;
        st_next[0].cz    = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                st_next[0].cx = y0;
                st_next[0].cy = -x0;
                st_next[0].cz = tab_angle(2 * ATAN_TAB[0]);
            end
            else
            begin
                st_next[0].cx = -y0;
                st_next[0].cy = x0;
                st_next[0].cz = -tab_angle(2 * ATAN_TAB[0]);
            end
        end
        sqx_next = point.vel_x * point.vel_x;
        sqy_next = point.vel_y * point.vel_y;
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        always_comb
        begin
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            dx = st_reg[k-1].cy >>> (k - 1);
            dy = st_reg[k-1].cx >>> (k - 1);
            st_next[k] = st_reg[k-1];
            if (st_reg[k-1].cy > 0)
            begin
                st_next[k].cx = st_reg[k-1].cx + dx;
                st_next[k].cy = st_reg[k-1].cy - dy;
                st_next[k].cz = st_reg[k-1].cz + tab_angle(ATAN_TAB[k-1]);
            end
            else
            begin
                st_next[k].cx = st_reg[k-1].cx - dx;
                st_next[k].cy = st_reg[k-1].cy + dy;
                st_next[k].cz = st_reg[k-1].cz - tab_angle(ATAN_TAB[k-1]);
            end
            if (k == 1)
                st_next[k].slow = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) <= cfg.speed_sq_min;
        end
    end

    // round to Q3.13 and wrap once
    always_comb
    begin
        zx = RW'(st_reg[N].cz);
        if (ANG_FRAC >= 13)
            zr = (zx + RW'(RND_HALF)) >>> RND_SHIFT;
        else
            zr = zx <<< UP_SHIFT;
        if (zr > RW'(YAW_PI))
            zr = zr - RW'(YAW_TWO_PI);
        else if (zr <= -RW'(YAW_PI))
            zr = zr + RW'(YAW_TWO_PI);
        item_next.pos_x = st_reg[N].pos_x;
        item_next.pos_y = st_reg[N].pos_y;
        item_next.slow  = st_reg[N].slow;
        item_next.aim   = zr[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N:0], point.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= N; k++)
                st_reg[k] <= st_next[k];
            sqx_reg  <= sqx_next[30:0];
            sqy_reg  <= sqy_next[30:0];
            item_reg <= item_next;
        end
    end
endmodule

FILE: design/hysl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_queue
// Four-entry queue between the heading front and the limiter back.
// ----------------------------------------------------------------------------
module hysl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  hysl_pkg::item_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output hysl_pkg::item_t rd_data
);
    import hysl_pkg::*;

    item_t       mem_reg [0:3];
    logic [1:0]  wp_reg;
    logic [1:0]  rp_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        push;
    logic        pop;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign cnt_next = cnt_reg + 3'(push) - 3'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

FILE: design/hysl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysl_back
// Slew-limits the yaw toward the aim, forms the smoothed yaw rate and holds
// the command in an output register.
// ----------------------------------------------------------------------------
module hysl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hysl_pkg::cfg_t  cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  hysl_pkg::item_t q_data,
    hysl_cmd_if.source      cmd
);
    import hysl_pkg::*;

    logic               out_valid_reg;
    logic signed [15:0] held_yaw_reg;
    logic signed [15:0] held_yaw_next;
    logic signed [15:0] held_rate_reg;
    logic signed [15:0] held_rate_next;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic        [30:0] z_reg;

    logic               take;
    logic signed [17:0] c;
    logic signed [17:0] a;
    logic signed [17:0] d;
    logic signed [17:0] s;
    logic signed [17:0] yaw;
    logic signed [16:0] inv;
    logic signed [34:0] prod;
    logic signed [34:0] rnd;
    logic signed [25:0] rate;
    logic signed [25:0] rmax;
    logic signed [25:0] sum;
    logic signed [25:0] avg;
    logic               stepped;

    assign take    = q_valid && (!out_valid_reg || cmd.ready);
    assign q_ready = take;

    always_comb
    begin
        c    = 18'(held_yaw_reg);
        a    = q_data.slow ? c : 18'(q_data.aim);
        d    = a - c;
        s    = 18'($signed({1'b0, cfg.yaw_step_max}));
        rmax = 26'($signed({1'b0, cfg.yaw_rate_max}));
        inv  = $signed({1'b0, cfg.inv_tick});
        prod = d * inv;
        rnd  = prod + 35'sd512;
        stepped = 1'b0;
        yaw  = a;
        priority if (d > 18'sd25736)
        begin
            if (d - 18'sd51472 < -s)
            begin
                yaw = c - s;
                stepped = 1'b1;
            end
            rate = -rmax;
        end
        else if (d < -18'sd25736)
        begin
            if (d + 18'sd51472 > s)
            begin
                yaw = c + s;
                stepped = 1'b1;
            end
            rate = rmax;
        end
        else if (d < -s)
        begin
            yaw = c - s;
            stepped = 1'b1;
            rate = -rmax;
        end
        else if (d > s)
        begin
            yaw = c + s;
            stepped = 1'b1;
            rate = rmax;
        end
        else
        begin
            rate = 26'(rnd >>> 10);
        end
        if (stepped)
        begin
            if (yaw > 18'sd25736)
                yaw = yaw - 18'sd51472;
            else if (yaw <= -18'sd25736)
                yaw = yaw + 18'sd51472;
        end
        sum = 26'(held_rate_reg) + rate;
        avg = sum >>> 1;
        held_yaw_next = yaw[15:0];
        if (avg > 26'sd32767)
            held_rate_next = 16'sh7FFF;
        else if (avg < -26'sd32768)
            held_rate_next = 16'sh8000;
        else
            held_rate_next = avg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_yaw_reg  <= '0;
            held_rate_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                held_yaw_reg  <= held_yaw_next;
                held_rate_reg <= held_rate_next;
            end
            else if (cmd.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= q_data.pos_x;
            y_reg <= q_data.pos_y;
            z_reg <= cfg.hover_height;
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.cmd_x        = x_reg;
    assign cmd.cmd_y        = y_reg;
    assign cmd.cmd_z        = z_reg;
    assign cmd.cmd_yaw      = held_yaw_reg;
    assign cmd.cmd_yaw_rate = held_rate_reg;
endmodule

FILE: design/heading_yaw_slew_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_yaw_slew_limiter
// Turns trajectory points into position, height, slew-limited yaw and
// smoothed yaw rate commands.
//
// Usage:
//   point: one transaction per trajectory point (pos_x, pos_y, vel_x, vel_y).
//   cmd:   one transaction per point, in order (cmd_x, cmd_y, cmd_z, cmd_yaw,
//          cmd_yaw_rate).
//   Configuration: cfg_we writes cfg_data to register cfg_index; write only
//   while no point is in flight. Indexes above four are ignored.
//   Path: a point passes the heading pipeline registers, then the queue,
//   then the limiter output register.
//   Throughput: one point per cycle while cmd is not stalled; the held yaw
//   and rate loop closes through one register; the CORDIC is fully pipelined.
//   Stall: a held cmd fills the four-entry queue, then the heading pipeline
//   freezes and point.ready drops.
//   Reset: valid flags, pointers, held yaw and rate clear, config takes defaults.
// ----------------------------------------------------------------------------
module heading_yaw_slew_limiter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hysl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hysl_pkg::CFG_DATA_W-1:0]    cfg_data,
    hysl_point_if.sink                         point,
    hysl_cmd_if.source                         cmd
);
    import hysl_pkg::*;

    cfg_t  cfg_reg;
    logic  fr_valid;
    logic  fr_ready;
    item_t fr_data;
    logic  q_valid;
    logic  q_ready;
    item_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hover_height <= 31'd52429;
            cfg_reg.yaw_step_max <= 15'd257;
            cfg_reg.yaw_rate_max <= 15'd3217;
            cfg_reg.inv_tick     <= 16'd12800;
            cfg_reg.speed_sq_min <= 32'd655;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOVER_HEIGHT: cfg_reg.hover_height <= cfg_data[30:0];
                CFG_YAW_STEP_MAX: cfg_reg.yaw_step_max <= cfg_data[14:0];
                CFG_YAW_RATE_MAX: cfg_reg.yaw_rate_max <= cfg_data[14:0];
                CFG_INV_TICK:     cfg_reg.inv_tick     <= cfg_data[15:0];
                CFG_SPEED_SQ_MIN: cfg_reg.speed_sq_min <= cfg_data;
                default:          ;
            endcase
        end
    end

    hysl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .point    (point),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_data  (fr_data)
    );

    hysl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    hysl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .cmd     (cmd)
    );
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heading_yaw_slew_limiter. Trajectory points are fed
// from a directed table and then from random phases under several register
// settings. A bit-accurate heading and slew predictor works out every command,
// which is compared field by field with the commands that come out in order.
// ----------------------------------------------------------------------------
module testbench;
    import hysl_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 30;
    localparam int  HOLD_CYCLES  = 250;
    localparam int  PHASES       = 7;
    localparam int  PHASE_POINTS = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [30:0] z;
        logic signed [15:0] yaw;
        logic signed [15:0] rate;
    } cmd_t;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [31:0]             data;
        logic signed [31:0]      px;
        logic signed [31:0]      py;
        logic signed [15:0]      vx;
        logic signed [15:0]      vy;
        bit                      typed;
        logic signed [15:0]      eyaw;
        logic signed [15:0]      erate;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hysl_point_if point ();
    hysl_cmd_if   cmd ();

    heading_yaw_slew_limiter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point),
        .cmd       (cmd)
    );

    cmd_t  pending_cmds[$];
    row_t  rows[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    jitter_on = 1'b1;
    bit    hold_go = 1'b0;
    bit    hold_off = 1'b0;

    logic [30:0] m_height;
    logic [14:0] m_step;
    logic [14:0] m_rate_max;
    logic [15:0] m_inv_tick;
    logic [31:0] m_speed_min;
    logic signed [15:0] m_yaw;
    logic signed [15:0] m_rate;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        point.valid = 1'b0;
        point.pos_x = '0;
        point.pos_y = '0;
        point.vel_x = '0;
        point.vel_y = '0;
        cmd.ready   = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic longint round_atan(input longint t);
        return (t + (64'sd1 <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
    endfunction

    function automatic longint wrap_pi(input longint a);
        if (a > YAW_PI)
            return a - YAW_TWO_PI;
        else if (a <= -YAW_PI)
            return a + YAW_TWO_PI;
        return a;
    endfunction

    function automatic longint aim_heading(input longint vx, input longint vy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint q;
        longint half;
        x = vx * 256;
        y = vy * 256;
        z = 0;
        q = round_atan(2 * ATAN_TAB[0]);
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = q;
            end
            else
            begin
                x = -y;
                y = t;
                z = -q;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + round_atan(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - round_atan(ATAN_TAB[i]);
            end
        end
        if (ANG_FRAC >= 13)
        begin
            half = (RND_SHIFT > 0) ? (64'sd1 <<< (RND_SHIFT - 1)) : 0;
            z = (z + half) >>> RND_SHIFT;
        end
        else
            z = z <<< UP_SHIFT;
        return wrap_pi(z);
    endfunction

    function automatic cmd_t limit_heading(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [15:0] vx,
                                           input logic signed [15:0] vy);
        cmd_t   r;
        longint c;
        longint a;
        longint d;
        longint yaw;
        longint rate;
        longint avg;
        longint s;
        longint rm;
        longint sp;
        bit     stepped;
        c = m_yaw;
        s = m_step;
        rm = m_rate_max;
        stepped = 1'b0;
        sp = longint'(vx) * vx + longint'(vy) * vy;
        a = (sp <= longint'(m_speed_min)) ? c : aim_heading(vx, vy);
        d = a - c;
        if (d > YAW_PI)
        begin
            if (d - YAW_TWO_PI < -s)
            begin
                yaw = c - s;
                stepped = 1'b1;
            end
            else
                yaw = a;
            rate = -rm;
        end
        else if (d < -YAW_PI)
        begin
            if (d + YAW_TWO_PI > s)
            begin
                yaw = c + s;
                stepped = 1'b1;
            end
            else
                yaw = a;
            rate = rm;
        end
        else if (d < -s)
        begin
            yaw = c - s;
            stepped = 1'b1;
            rate = -rm;
        end
        else if (d > s)
        begin
            yaw = c + s;
            stepped = 1'b1;
            rate = rm;
        end
        else
        begin
            yaw = a;
            rate = (d * longint'(m_inv_tick) + 512) >>> 10;
        end
        if (stepped)
            yaw = wrap_pi(yaw);
        avg = (longint'(m_rate) + rate) >>> 1;
        if (avg > 32767)
            avg = 32767;
        if (avg < -32768)
            avg = -32768;
        m_yaw = yaw[15:0];
        m_rate = avg[15:0];
        r.x = px;
        r.y = py;
        r.z = m_height;
        r.yaw = yaw[15:0];
        r.rate = avg[15:0];
        return r;
    endfunction

    task automatic wait_idle();
        wait (pending_cmds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HOVER_HEIGHT: m_height = data[30:0];
            CFG_YAW_STEP_MAX: m_step = data[14:0];
            CFG_YAW_RATE_MAX: m_rate_max = data[14:0];
            CFG_INV_TICK:     m_inv_tick = data[15:0];
            CFG_SPEED_SQ_MIN: m_speed_min = data;
            default: ;
        endcase
    endtask

    task automatic send_point(input row_t r);
        cmd_t e;
        int   gap;
        if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            point.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point.valid <= 1'b1;
        point.pos_x <= r.px;
        point.pos_y <= r.py;
        point.vel_x <= r.vx;
        point.vel_y <= r.vy;
        do
            @(posedge clk);
        while (!point.ready);
        e = limit_heading(r.px, r.py, r.vx, r.vy);
        if (r.typed)
        begin
            e.yaw = r.eyaw;
            e.rate = r.erate;
        end
        pending_cmds.insert(pending_cmds.size(), e);
    endtask

    task automatic add_point(input logic signed [15:0] vx, input logic signed [15:0] vy);
        row_t r;
        r = '{default: '0};
        r.px = $urandom;
        r.py = $urandom;
        r.vx = vx;
        r.vy = vy;
        rows.insert(rows.size(), r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        rows.insert(rows.size(), r);
    endtask

    task automatic report(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // receiver: random stall bursts, plus the long hold-off
    initial
    begin
        int stall;
        cmd_t e;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (cmd.valid && cmd.ready)
            begin
                if (pending_cmds.size() == 0)
                    report("unexpected transaction", 0, 1);
                else
                begin
                    e = pending_cmds.pop_front();
                    if (cmd.cmd_x !== e.x) report("cmd_x", e.x, cmd.cmd_x);
                    if (cmd.cmd_y !== e.y) report("cmd_y", e.y, cmd.cmd_y);
                    if (cmd.cmd_z !== e.z) report("cmd_z", e.z, cmd.cmd_z);
                    if (cmd.cmd_yaw !== e.yaw) report("cmd_yaw", e.yaw, cmd.cmd_yaw);
                    if (cmd.cmd_yaw_rate !== e.rate)
                        report("cmd_yaw_rate", e.rate, cmd.cmd_yaw_rate);
                end
            end
            if (stall > 0)
                stall--;
            else if (jitter_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 15);
            cmd.ready <= !hold_off && stall == 0;
        end
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        row_t r;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [31:0] step;
        logic [31:0] rmax;
        logic [31:0] inv;
        logic [31:0] smin;
        logic [31:0] height;
        int kind;

        m_height = 31'd52429;
        m_step = 15'd257;
        m_rate_max = 15'd3217;
        m_inv_tick = 16'd12800;
        m_speed_min = 32'd655;
        m_yaw = '0;
        m_rate = '0;

        r = '{default: '0};
        r.px = 32'sh7FFFFFFF;
        r.py = 32'sh80000000;
        r.typed = 1'b1;
        rows.insert(rows.size(), r);
        add_point(16'sd32767, 16'sd0);
        add_point(-16'sd32768, 16'sd0);
        add_point(16'sd0, 16'sd32767);
        add_point(16'sd0, -16'sd32768);
        add_point(-16'sd32768, -16'sd32768);
        add_point(16'sd32767, 16'sd32767);
        add_point(16'sd25, 16'sd5);
        add_point(-16'sd26, 16'sd0);
        add_cfg(CFG_YAW_STEP_MAX, 32'd32767);
        add_point(-16'sd256, 16'sd1);
        add_point(-16'sd256, -16'sd1);
        add_point(-16'sd256, 16'sd1);
        add_cfg(CFG_YAW_STEP_MAX, 32'd100);
        add_point(-16'sd256, -16'sd1);
        add_point(16'sd0, 16'sd256);
        add_point(16'sd0, -16'sd256);
        add_cfg(CFG_YAW_STEP_MAX, 32'd0);
        add_point(16'sd256, 16'sd0);
        add_cfg(CFG_YAW_STEP_MAX, 32'd25736);
        add_cfg(CFG_INV_TICK, 32'd65535);
        add_point(16'sd256, 16'sd0);
        add_point(-16'sd256, 16'sd3);
        add_point(16'sd1, -16'sd300);
        add_cfg(CFG_UNUSED_IDX, 32'hFFFFFFFF);
        add_cfg(CFG_INV_TICK, 32'd12800);
        add_cfg(CFG_YAW_STEP_MAX, 32'd257);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                point.valid <= 1'b0;
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_point(rows[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            point.valid <= 1'b0;
            case (p)
                0: begin height = 0; step = 0; rmax = 32767; inv = 65535; smin = 0; end
                1: begin height = 32'hFFFFFFFF; step = 25736; rmax = 0; inv = 0;
                         smin = 32'hFFFFFFFF; end
                2: begin height = $urandom; step = 32767; rmax = $urandom_range(0, 32767);
                         inv = $urandom; smin = $urandom_range(0, 70000); end
                default: begin height = $urandom; step = $urandom_range(1, 3000);
                         rmax = $urandom_range(0, 32767); inv = $urandom_range(0, 65535);
                         smin = $urandom_range(0, 5000); end
            endcase
            write_reg(CFG_HOVER_HEIGHT, height);
            write_reg(CFG_YAW_STEP_MAX, step);
            write_reg(CFG_YAW_RATE_MAX, rmax);
            write_reg(CFG_INV_TICK, inv);
            write_reg(CFG_SPEED_SQ_MIN, smin);
            write_reg(CFG_UNUSED_IDX, $urandom);
            if (p == 3)
                hold_go = 1'b1;
            if (p == PHASES - 1)
                jitter_on = 1'b0;
            for (int n = 0; n < ((p == 1) ? 20 : PHASE_POINTS + 10); n++)
            begin
                kind = $urandom_range(0, 9);
                vx = $urandom;
                vy = $urandom;
                if (kind == 0)
                begin
                    vx = $signed($urandom_range(0, 60)) - 30;
                    vy = $signed($urandom_range(0, 60)) - 30;
                end
                else if (kind == 1)
                begin
                    vx = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
                    vy = ($urandom_range(0, 2) == 0) ? 16'sh0000 : vy;
                end
                else
                begin
                    vx = vx >>> $urandom_range(0, 10);
                    vy = vy >>> $urandom_range(0, 10);
                end
                r = '{default: '0};
                r.px = $urandom;
                r.py = $urandom;
                r.vx = vx;
                r.vy = vy;
                send_point(r);
            end
        end
        point.valid <= 1'b0;

        wait (pending_cmds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

FILE: filelist.f
design/hysl_pkg.sv
design/hysl_point_if.sv
design/hysl_cmd_if.sv
design/hysl_front.sv
design/hysl_queue.sv
design/hysl_back.sv
design/heading_yaw_slew_limiter.sv
tb/testbench.sv
